>>> hw/rtl/rsi_pkg.sv
package rsi_pkg;

    localparam int COORD_WIDTH     = 20;
    localparam int COORD_FRAC_BITS = 8;
    localparam int DIR_FRAC_BITS   = 14;
    localparam int DIR_WIDTH       = DIR_FRAC_BITS + 2;
    localparam int DIST_WIDTH      = COORD_WIDTH - 1;

    // widths of the intermediate terms, all exact
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PRS_W  = DIR_WIDTH + COORD_WIDTH;
    localparam int PRN_W  = 2 * DIR_WIDTH;
    localparam int PDR_W  = DIFF_W + DIR_WIDTH;
    localparam int PDS_W  = DIFF_W + COORD_WIDTH;
    localparam int FACE_W = PRN_W + 1;
    localparam int RXS_W  = PRS_W + 1;
    localparam int DXR_W  = PDR_W + 1;
    localparam int DXS_W  = PDS_W + 1;
    localparam int DEN_W  = RXS_W;

    // quotient reaches 2^DIST_WIDTH exactly when |dxs| >= |rxs| << SAT_SHIFT
    localparam int SAT_SHIFT = DIST_WIDTH - DIR_FRAC_BITS;
    localparam int NUM_W     = DXS_W + DIR_FRAC_BITS;
    localparam int REM_A     = DEN_W + DIST_WIDTH;
    localparam int REM_B     = (NUM_W > DXS_W + 1) ? NUM_W : DXS_W + 1;
    localparam int REM_W     = (REM_A > REM_B) ? REM_A : REM_B;

    localparam logic [1:0] OUT_BACK      = 2'd0;
    localparam logic [1:0] OUT_MISS      = 2'd1;
    localparam logic [1:0] OUT_HIT       = 2'd2;
    localparam logic [1:0] OUT_COLLINEAR = 2'd3;

    typedef struct packed {
        logic signed [FACE_W-1:0] facing;
        logic signed [RXS_W-1:0]  rxs;
        logic signed [DXR_W-1:0]  dxr;
        logic signed [DXS_W-1:0]  dxs;
    } rsi_cross_t;

    typedef struct packed {
        logic                  do_div;
        logic                  sat;
        logic                  hit;
        logic [1:0]            outcome;
        logic [DIST_WIDTH-1:0] preset;
        logic [REM_W-1:0]      rem;
        logic [DEN_W-1:0]      den;
        logic [DIST_WIDTH-1:0] quo;
    } rsi_div_t;

endpackage

>>> hw/rtl/rsi_cross.sv
module rsi_cross
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       px,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       py,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]         rx,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]         ry,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       qx,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       qy,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       sx,
    input  logic signed [rsi_pkg::COORD_WIDTH-1:0]       sy,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]         nx,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]         ny,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output rsi_pkg::rsi_cross_t                          out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic signed [rsi_pkg::DIFF_W-1:0]    dx_reg, dy_reg;
    logic signed [rsi_pkg::DIR_WIDTH-1:0] rx_reg, ry_reg;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] sx_reg, sy_reg;
    logic signed [rsi_pkg::PRS_W-1:0]     p_rxsy_reg, p_rysx_reg;
    logic signed [rsi_pkg::PRN_W-1:0]     p_rxnx_reg, p_ryny_reg;

    logic signed [rsi_pkg::PDR_W-1:0]     p_dxry_reg, p_dyrx_reg;
    logic signed [rsi_pkg::PDS_W-1:0]     p_dxsy_reg, p_dysx_reg;
    logic signed [rsi_pkg::RXS_W-1:0]     rxs_reg;
    logic signed [rsi_pkg::FACE_W-1:0]    facing_reg;

    rsi_pkg::rsi_cross_t out_reg;

    assign r3       = ~v3_reg | out_ready;
    assign r2       = ~v2_reg | r3;
    assign r1       = ~v1_reg | r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            dx_reg     <= rsi_pkg::DIFF_W'(qx) - rsi_pkg::DIFF_W'(px);
            dy_reg     <= rsi_pkg::DIFF_W'(qy) - rsi_pkg::DIFF_W'(py);
            rx_reg     <= rx;
            ry_reg     <= ry;
            sx_reg     <= sx;
            sy_reg     <= sy;
            p_rxsy_reg <= rx * sy;
            p_rysx_reg <= ry * sx;
            p_rxnx_reg <= rx * nx;
            p_ryny_reg <= ry * ny;
        end
        if (r2 && v1_reg)
        begin
            p_dxry_reg <= dx_reg * ry_reg;
            p_dyrx_reg <= dy_reg * rx_reg;
            p_dxsy_reg <= dx_reg * sy_reg;
            p_dysx_reg <= dy_reg * sx_reg;
            rxs_reg    <= rsi_pkg::RXS_W'(p_rxsy_reg) - rsi_pkg::RXS_W'(p_rysx_reg);
            facing_reg <= rsi_pkg::FACE_W'(p_rxnx_reg) + rsi_pkg::FACE_W'(p_ryny_reg);
        end
        if (r3 && v2_reg)
        begin
            out_reg.facing <= facing_reg;
            out_reg.rxs    <= rxs_reg;
            out_reg.dxr    <= rsi_pkg::DXR_W'(p_dxry_reg) - rsi_pkg::DXR_W'(p_dyrx_reg);
            out_reg.dxs    <= rsi_pkg::DXS_W'(p_dxsy_reg) - rsi_pkg::DXS_W'(p_dysx_reg);
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

>>> hw/rtl/rsi_classify.sv
module rsi_classify
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rsi_pkg::rsi_cross_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rsi_pkg::rsi_div_t   out_data
);

    logic v1_reg, v2_reg;
    logic r1, r2;

    logic [rsi_pkg::RXS_W-1:0] rxs_u, mag_rxs;
    logic [rsi_pkg::DXR_W-1:0] dxr_u, mag_dxr;
    logic [rsi_pkg::DXS_W-1:0] dxs_u, mag_dxs;
    logic neg, t_ok, u_sign_ok;

    logic                      back_reg, rxs_zero_reg, dxr_zero_reg;
    logic                      t_ok_reg, u_sign_ok_reg;
    logic [rsi_pkg::RXS_W-1:0] mag_rxs_reg;
    logic [rsi_pkg::DXR_W-1:0] mag_dxr_reg;
    logic [rsi_pkg::DXS_W-1:0] mag_dxs_reg;

    logic u_ok, sat;
    rsi_pkg::rsi_div_t div_next, out_reg;

    assign r2       = ~v2_reg | out_ready;
    assign r1       = ~v1_reg | r2;
    assign in_ready = r1;

    always_comb
    begin
        rxs_u     = in_data.rxs;
        dxr_u     = in_data.dxr;
        dxs_u     = in_data.dxs;
        mag_rxs   = rxs_u[rsi_pkg::RXS_W-1] ? (~rxs_u + rsi_pkg::RXS_W'(1)) : rxs_u;
        mag_dxr   = dxr_u[rsi_pkg::DXR_W-1] ? (~dxr_u + rsi_pkg::DXR_W'(1)) : dxr_u;
        mag_dxs   = dxs_u[rsi_pkg::DXS_W-1] ? (~dxs_u + rsi_pkg::DXS_W'(1)) : dxs_u;
        neg       = rxs_u[rsi_pkg::RXS_W-1];
        t_ok      = (in_data.dxs == '0) || (dxs_u[rsi_pkg::DXS_W-1] == neg);
        u_sign_ok = (in_data.dxr == '0) || (dxr_u[rsi_pkg::DXR_W-1] == neg);
    end

    // second stage: range tests, saturation check, divider setup
    always_comb
    begin
        u_ok = u_sign_ok_reg && (mag_dxr_reg <= rsi_pkg::DXR_W'(mag_rxs_reg));
        sat  = rsi_pkg::REM_W'(mag_dxs_reg) >=
               (rsi_pkg::REM_W'(mag_rxs_reg) << rsi_pkg::SAT_SHIFT);
        div_next         = '0;
        div_next.sat     = sat;
        div_next.rem     = rsi_pkg::REM_W'(mag_dxs_reg) << rsi_pkg::DIR_FRAC_BITS;
        div_next.den     = mag_rxs_reg;
        priority if (back_reg)
        begin
            div_next.outcome = rsi_pkg::OUT_BACK;
        end
        else if (rxs_zero_reg)
        begin
            if (dxr_zero_reg)
            begin
                div_next.outcome = rsi_pkg::OUT_COLLINEAR;
                div_next.hit     = 1'b1;
                div_next.preset  = rsi_pkg::DIST_WIDTH'(1) << rsi_pkg::COORD_FRAC_BITS;
            end
            else
            begin
                div_next.outcome = rsi_pkg::OUT_MISS;
            end
        end
        else if (t_ok_reg && u_ok)
        begin
            div_next.outcome = rsi_pkg::OUT_HIT;
            div_next.hit     = 1'b1;
            div_next.do_div  = 1'b1;
        end
        else
        begin
            div_next.outcome = rsi_pkg::OUT_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            back_reg      <= ~in_data.facing[rsi_pkg::FACE_W-1] && (in_data.facing != '0);
            rxs_zero_reg  <= (in_data.rxs == '0);
            dxr_zero_reg  <= (in_data.dxr == '0);
            t_ok_reg      <= t_ok;
            u_sign_ok_reg <= u_sign_ok;
            mag_rxs_reg   <= mag_rxs;
            mag_dxr_reg   <= mag_dxr;
            mag_dxs_reg   <= mag_dxs;
        end
        if (r2 && v1_reg)
            out_reg <= div_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

>>> hw/rtl/rsi_divider.sv
module rsi_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsi_pkg::rsi_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rsi_pkg::rsi_div_t out_data
);

    localparam int N = rsi_pkg::DIST_WIDTH;

    logic              vld_reg [N];
    logic              rdy     [N];
    logic              vsrc    [N];
    rsi_pkg::rsi_div_t st_reg  [N];
    rsi_pkg::rsi_div_t src     [N];
    rsi_pkg::rsi_div_t nxt     [N];

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [rsi_pkg::REM_W-1:0] shifted;

        if (k == 0)
        begin : g_first
            assign src[k]  = in_data;
            assign vsrc[k] = in_valid;
        end
        else
        begin : g_rest
            assign src[k]  = st_reg[k-1];
            assign vsrc[k] = vld_reg[k-1];
        end

        if (k == N - 1)
        begin : g_last
            assign rdy[k] = ~vld_reg[k] | out_ready;
        end
        else
        begin : g_mid
            assign rdy[k] = ~vld_reg[k] | rdy[k+1];
        end

        assign shifted = rsi_pkg::REM_W'(src[k].den) << (N - 1 - k);

        always_comb
        begin
            nxt[k] = src[k];
            if (src[k].rem >= shifted)
            begin
                nxt[k].rem            = src[k].rem - shifted;
                nxt[k].quo[N - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vsrc[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vsrc[k])
                st_reg[k] <= nxt[k];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

>>> hw/rtl/ray_segment_intersect.sv
// Tests one 2D ray against one segment per item and returns hit, outcome and the
// ray parameter t in unsigned Q11.8, saturated. A new item is taken every cycle while
// m_axis_tready is high; each item passes three stages for the differences, products
// and cross sums, two for the culling and range tests, 19 stages of restoring
// division (one quotient bit each, which sets the depth) and the output register.
// Back-facing segments and parallel non-collinear cases give distance zero.
module ray_segment_intersect
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x, origin_y, dir_x, dir_y, seg_start_x, seg_start_y,
    // seg_vec_x, seg_vec_y, normal_x, normal_y
    input  logic [183:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // distance, zero padded
    output logic [23:0]  m_axis_tdata,
    // hit, outcome
    output logic [2:0]   m_axis_tuser
);

    logic                c_valid, c_ready;
    rsi_pkg::rsi_cross_t c_data;
    logic                k_valid, k_ready;
    rsi_pkg::rsi_div_t   k_data;
    logic                d_valid, d_ready;
    rsi_pkg::rsi_div_t   d_data;

    logic                            o_valid_reg;
    logic                            o_hit_reg;
    logic [1:0]                      o_outcome_reg;
    logic [rsi_pkg::DIST_WIDTH-1:0]  o_dist_reg;
    logic [rsi_pkg::DIST_WIDTH-1:0]  dist_next;

    rsi_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .px        (s_axis_tdata[19:0]),
        .py        (s_axis_tdata[39:20]),
        .rx        (s_axis_tdata[55:40]),
        .ry        (s_axis_tdata[71:56]),
        .qx        (s_axis_tdata[91:72]),
        .qy        (s_axis_tdata[111:92]),
        .sx        (s_axis_tdata[131:112]),
        .sy        (s_axis_tdata[151:132]),
        .nx        (s_axis_tdata[167:152]),
        .ny        (s_axis_tdata[183:168]),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    rsi_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (k_valid),
        .out_ready (k_ready),
        .out_data  (k_data)
    );

    rsi_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (k_valid),
        .in_ready  (k_ready),
        .in_data   (k_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    assign d_ready = ~o_valid_reg | m_axis_tready;

    always_comb
    begin
        if (!d_data.do_div)
            dist_next = d_data.preset;
        else if (d_data.sat)
            dist_next = '1;
        else
            dist_next = d_data.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (d_ready)
            o_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && d_valid)
        begin
            o_hit_reg     <= d_data.hit;
            o_outcome_reg <= d_data.outcome;
            o_dist_reg    <= dist_next;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {5'b0, o_dist_reg};
    assign m_axis_tuser  = {o_outcome_reg, o_hit_reg};

endmodule

>>> hw/rtl/rsi_checker.sv
module rsi_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [183:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [23:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // hit flag agrees with the outcome code
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] ==
            ((m_axis_tuser[2:1] == rsi_pkg::OUT_HIT) ||
             (m_axis_tuser[2:1] == rsi_pkg::OUT_COLLINEAR))))
        else $error("hit flag disagrees with outcome");

    // a miss or a culled segment carries no distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
        else $error("nonzero distance on a miss");

    // collinear hit always reports t of one
    a_collinear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == rsi_pkg::OUT_COLLINEAR)) |->
            (m_axis_tdata == (24'd1 << rsi_pkg::COORD_FRAC_BITS)))
        else $error("collinear distance wrong");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind ray_segment_intersect rsi_checker u_rsi_checker (.*);
